>>> rtl/ballet128_block_cipher_macros.svh
// Assertion macros used by the checker file of the block cipher.
`ifndef BALLET128_BLOCK_CIPHER_MACROS_SVH
`define BALLET128_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BLT_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("block cipher check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define BLT_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("block cipher check failed: next-cycle implication");

`endif

>>> rtl/blt_pkg.sv
// Shared constants and types of the block cipher.
package blt_pkg;

	localparam int ROUNDS_LONG_KEY  = 48;
	localparam int ROUNDS_SHORT_KEY = 46;
	localparam int MAX_ROUNDS  = (ROUNDS_LONG_KEY > ROUNDS_SHORT_KEY) ?
		ROUNDS_LONG_KEY : ROUNDS_SHORT_KEY;
	localparam int STORE_DEPTH = MAX_ROUNDS;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(MAX_ROUNDS + 1);

	localparam int KEY_W      = 64;
	localparam int BLOCK_W    = 64;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_W0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_W1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_W2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_W3     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

	typedef struct packed {
		logic              keys_ready;
		logic              key_long;
	} blt_cfg_sts_t;

	typedef struct packed {
		logic              exp_init;
		logic              exp_step;
		logic [CNT_W-1:0]  exp_idx;
		logic              ld_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              rnd_en;
		logic              rnd_odd;
		logic              dec;
		logic              out_load;
	} blt_cmd_t;

endpackage

>>> rtl/ballet128_block_cipher.sv
// Top level of the 128-bit block cipher core with 128- or 256-bit key.
// The core takes one word at a time and runs one round per cycle on a
// single round unit, reading round keys from a 48 x 64 memory with a
// registered read port. A word is taken when the core is idle; it then
// reads the first round key, runs n rounds (n = 46 for the short key,
// 48 for the long key) and loads the result register, which waits while
// a previous result is still held under out_stall.
// After any key or key-length write, the next word first runs the key
// schedule once, one round key per cycle. The result
// register holds a finished word while the core already takes the next.
module ballet128_block_cipher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [blt_pkg::BLOCK_W-1:0]    block_hi,
	input  logic [blt_pkg::BLOCK_W-1:0]    block_lo,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [blt_pkg::BLOCK_W-1:0]    result_hi,
	output logic [blt_pkg::BLOCK_W-1:0]    result_lo,
	input  logic                           cfg_wr_en,
	input  logic [blt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import blt_pkg::*;

	blt_cfg_sts_t     sts;
	blt_cmd_t         cmd;
	logic             exp_done;
	logic [KEY_W-1:0] key_w0, key_w1, key_w2, key_w3;

	blt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.exp_done  (exp_done),
		.key_w0    (key_w0),
		.key_w1    (key_w1),
		.key_w2    (key_w2),
		.key_w3    (key_w3),
		.sts       (sts)
	);

	blt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.exp_done  (exp_done),
		.cmd       (cmd)
	);

	blt_dp u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.key_long  (sts.key_long),
		.key_w0    (key_w0),
		.key_w1    (key_w1),
		.key_w2    (key_w2),
		.key_w3    (key_w3),
		.block_hi  (block_hi),
		.block_lo  (block_lo),
		.result_hi (result_hi),
		.result_lo (result_lo)
	);

endmodule

>>> rtl/blt_cfg.sv
// Key and key-length registers with the expanded-key flag.
module blt_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [blt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          exp_done,
	output logic [blt_pkg::KEY_W-1:0]      key_w0,
	output logic [blt_pkg::KEY_W-1:0]      key_w1,
	output logic [blt_pkg::KEY_W-1:0]      key_w2,
	output logic [blt_pkg::KEY_W-1:0]      key_w3,
	output blt_pkg::blt_cfg_sts_t          sts
);
	import blt_pkg::*;

	logic [KEY_W-1:0] key_w0_q, key_w1_q, key_w2_q, key_w3_q;
	logic             key_long_q;
	logic             keys_ready_q;
	logic             hit;

	assign hit = cfg_wr_en && (cfg_index == REG_KEY_W0 || cfg_index == REG_KEY_W1 ||
		cfg_index == REG_KEY_W2 || cfg_index == REG_KEY_W3 || cfg_index == REG_KEY_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_w0_q     <= '0;
			key_w1_q     <= '0;
			key_w2_q     <= '0;
			key_w3_q     <= '0;
			key_long_q   <= 1'b0;
			keys_ready_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_KEY_W0:     key_w0_q   <= cfg_wdata[KEY_W-1:0];
					REG_KEY_W1:     key_w1_q   <= cfg_wdata[KEY_W-1:0];
					REG_KEY_W2:     key_w2_q   <= cfg_wdata[KEY_W-1:0];
					REG_KEY_W3:     key_w3_q   <= cfg_wdata[KEY_W-1:0];
					REG_KEY_LENGTH: key_long_q <= cfg_wdata[0];
					default:        ;
				endcase
			end
			if (hit) begin
				keys_ready_q <= 1'b0;
			end else if (exp_done) begin
				keys_ready_q <= 1'b1;
			end
		end
	end

	assign key_w0         = key_w0_q;
	assign key_w1         = key_w1_q;
	assign key_w2         = key_w2_q;
	assign key_w3         = key_w3_q;
	assign sts.keys_ready = keys_ready_q;
	assign sts.key_long   = key_long_q;

endmodule

>>> rtl/blt_dp.sv
// Datapath: key schedule, round-key memory, round unit and result register.
module blt_dp (
	input  logic                         clk,
	input  blt_pkg::blt_cmd_t            cmd,
	input  logic                         key_long,
	input  logic [blt_pkg::KEY_W-1:0]     key_w0,
	input  logic [blt_pkg::KEY_W-1:0]     key_w1,
	input  logic [blt_pkg::KEY_W-1:0]     key_w2,
	input  logic [blt_pkg::KEY_W-1:0]     key_w3,
	input  logic [blt_pkg::BLOCK_W-1:0]   block_hi,
	input  logic [blt_pkg::BLOCK_W-1:0]   block_lo,
	output logic [blt_pkg::BLOCK_W-1:0]   result_hi,
	output logic [blt_pkg::BLOCK_W-1:0]   result_lo
);
	import blt_pkg::*;

	function automatic logic [31:0] rl32(input logic [31:0] x, input int n);
		rl32 = (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [63:0] rl64(input logic [63:0] x, input int n);
		rl64 = (x << n) | (x >> (64 - n));
	endfunction

	logic [63:0] rk_mem [STORE_DEPTH];
	logic [63:0] rk_q;
	logic [63:0] k0_q, k1_q, u0_q, u1_q;
	logic [63:0] k0_n, k1_n, u0_n, u1_n, idx64, wr_data;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] a_n, b_n, c_n, d_n, t, kh, kl, x1, x2;
	logic [BLOCK_W-1:0] result_hi_q, result_lo_q;

	assign idx64   = {{(64 - CNT_W){1'b0}}, cmd.exp_idx};
	assign wr_data = cmd.exp_idx[0] ? k1_q : k0_q;

	always_comb begin
		u0_n = u0_q;
		u1_n = u1_q;
		k0_n = k0_q;
		k1_n = k1_q;
		if (!cmd.exp_idx[0]) begin
			u0_n = u0_q ^ rl64(u1_q, 7) ^ rl64(u1_q, 17);
			k0_n = k0_q ^ rl64(k1_q, 3) ^ rl64(k1_q, 5) ^ idx64 ^ (key_long ? u0_n : 64'd0);
		end else begin
			u1_n = u1_q ^ rl64(u0_q, 7) ^ rl64(u0_q, 17);
			k1_n = k1_q ^ rl64(k0_q, 3) ^ rl64(k0_q, 5) ^ idx64 ^ (key_long ? u1_n : 64'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_init) begin
			k0_q <= key_w0;
			k1_q <= key_w1;
			u0_q <= key_w2;
			u1_q <= key_w3;
		end else if (cmd.exp_step) begin
			k0_q <= k0_n;
			k1_q <= k1_n;
			if (key_long) begin
				u0_q <= u0_n;
				u1_q <= u1_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_step) begin
			rk_mem[cmd.exp_idx[ADDR_W-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rk_q <= rk_mem[cmd.rd_addr];
		end
	end

	assign kh = rk_q[63:32];
	assign kl = rk_q[31:0];

	always_comb begin
		a_n = a_q;
		b_n = b_q;
		c_n = c_q;
		d_n = d_q;
		t   = '0;
		x1  = '0;
		x2  = '0;
		case ({cmd.dec, cmd.rnd_odd})
			2'b00: begin
				t   = b_q ^ c_q;
				b_n = b_q ^ kh;
				c_n = c_q ^ kl;
				a_n = rl32(a_q, 6) + rl32(t, 9);
				d_n = rl32(d_q, 15) + rl32(t, 14);
			end
			2'b01: begin
				t   = a_q ^ d_q;
				b_n = rl32(b_q, 6) + rl32(t, 9);
				c_n = rl32(c_q, 15) + rl32(t, 14);
				a_n = a_q ^ kh;
				d_n = d_q ^ kl;
			end
			2'b10: begin
				b_n = b_q ^ kh;
				c_n = c_q ^ kl;
				t   = b_n ^ c_n;
				x1  = a_q - rl32(t, 9);
				x2  = d_q - rl32(t, 14);
				a_n = rl32(x1, 26);
				d_n = rl32(x2, 17);
			end
			default: begin
				a_n = a_q ^ kh;
				d_n = d_q ^ kl;
				t   = a_n ^ d_n;
				x1  = b_q - rl32(t, 9);
				x2  = c_q - rl32(t, 14);
				b_n = rl32(x1, 26);
				c_n = rl32(x2, 17);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_data) begin
			a_q <= block_hi[63:32];
			b_q <= block_hi[31:0];
			c_q <= block_lo[63:32];
			d_q <= block_lo[31:0];
		end else if (cmd.rnd_en) begin
			a_q <= a_n;
			b_q <= b_n;
			c_q <= c_n;
			d_q <= d_n;
		end
		if (cmd.out_load) begin
			result_hi_q <= {b_q, a_q};
			result_lo_q <= {d_q, c_q};
		end
	end

	assign result_hi = result_hi_q;
	assign result_lo = result_lo_q;

endmodule

>>> rtl/blt_ctrl.sv
// Controller: sequences key expansion, round-key reads, rounds and output.
module blt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  func,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  blt_pkg::blt_cfg_sts_t sts,
	output logic                  exp_done,
	output blt_pkg::blt_cmd_t     cmd
);
	import blt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXPAND,
		S_PREP,
		S_ROUND,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q, n_m1, cnt_nx, rd_idx;
	logic             dec_q, out_vld_q, last;

	assign n_m1   = sts.key_long ? CNT_W'(ROUNDS_LONG_KEY - 1) : CNT_W'(ROUNDS_SHORT_KEY - 1);
	assign last   = (cnt_q == n_m1);
	assign cnt_nx = cnt_q + 1'b1;

	always_comb begin
		cmd          = '0;
		cmd.dec      = dec_q;
		cmd.exp_idx  = cnt_q;
		cmd.rnd_odd  = cnt_q[0];
		in_stall     = 1'b1;
		exp_done     = 1'b0;
		rd_idx       = '0;
		case (state_q)
			S_IDLE: begin
				in_stall     = 1'b0;
				cmd.ld_data  = in_valid;
				cmd.exp_init = in_valid;
			end
			S_EXPAND: begin
				cmd.exp_step = 1'b1;
				exp_done     = last;
			end
			S_PREP: begin
				cmd.rd_en = 1'b1;
			end
			S_ROUND: begin
				cmd.rnd_en = 1'b1;
				cmd.rd_en  = !last;
				rd_idx     = cnt_nx;
			end
			S_FINISH: begin
				cmd.out_load = !out_vld_q || !out_stall;
			end
			default: ;
		endcase
		cmd.rd_addr = dec_q ? ADDR_W'(n_m1 - rd_idx) : rd_idx[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			dec_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dec_q   <= func;
						cnt_q   <= '0;
						state_q <= sts.keys_ready ? S_PREP : S_EXPAND;
					end
				end
				S_EXPAND: begin
					if (last) begin
						cnt_q   <= '0;
						state_q <= S_PREP;
					end else begin
						cnt_q <= cnt_nx;
					end
				end
				S_PREP: begin
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					cnt_q <= cnt_nx;
					if (last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_vld_q;

endmodule

>>> rtl/blt_checker.sv
// Port-level checks of the block cipher and their binding to the top level.
`include "ballet128_block_cipher_macros.svh"

module blt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [blt_pkg::BLOCK_W-1:0] result_hi,
	input logic [blt_pkg::BLOCK_W-1:0] result_lo
);

	`BLT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`BLT_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(result_hi) && $stable(result_lo))
	`BLT_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
	`BLT_ASSERT_IMP(a_result_after_work, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind ballet128_block_cipher blt_checker u_blt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result_hi (result_hi),
	.result_lo (result_lo)
);

>>> tb/tb_ballet128_block_cipher.sv
// Self-checking testbench for the 128-bit block cipher core with 128- and 256-bit keys.
`timescale 1ns / 1ps

import blt_pkg::*;

typedef enum bit {
	ENCRYPT = 1'b0,
	DECRYPT = 1'b1
} cipher_func_e;

class block_tracker;
	localparam int REPORT_LIMIT = 10;

	bit [63:0]   key_word [4];
	bit          long_key;
	bit          keys_ready;
	bit [63:0]   round_key [STORE_DEPTH];
	logic [63:0] awaited_hi [$];
	logic [63:0] awaited_lo [$];
	int          mismatches;

	function new();
		key_word   = '{default: '0};
		long_key   = 1'b0;
		keys_ready = 1'b0;
		mismatches = 0;
	endfunction

	static function bit [31:0] rol32(bit [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	static function bit [63:0] rol64(bit [63:0] x, int n);
		return (x << n) | (x >> (64 - n));
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_KEY_W0:     key_word[0] = data;
			REG_KEY_W1:     key_word[1] = data;
			REG_KEY_W2:     key_word[2] = data;
			REG_KEY_W3:     key_word[3] = data;
			REG_KEY_LENGTH: long_key = data[0];
			default:        return;
		endcase
		keys_ready = 1'b0;
	endfunction

	function void note_block(cipher_func_e f, bit [63:0] hi, bit [63:0] lo);
		bit [63:0] k0, k1, u0, u1, rk;
		bit [31:0] a, b, c, d, t, kh, kl;
		int        n;
		n = long_key ? ROUNDS_LONG_KEY : ROUNDS_SHORT_KEY;
		if (!keys_ready) begin
			k0 = key_word[0];
			k1 = key_word[1];
			u0 = key_word[2];
			u1 = key_word[3];
			for (int i = 0; i < n; i++) begin
				if (i % 2 == 0) begin
					round_key[i] = k0;
					if (long_key) u0 ^= rol64(u1, 7) ^ rol64(u1, 17);
					k0 ^= rol64(k1, 3) ^ rol64(k1, 5) ^ 64'(i);
					if (long_key) k0 ^= u0;
				end else begin
					round_key[i] = k1;
					if (long_key) u1 ^= rol64(u0, 7) ^ rol64(u0, 17);
					k1 ^= rol64(k0, 3) ^ rol64(k0, 5) ^ 64'(i);
					if (long_key) k1 ^= u1;
				end
			end
			keys_ready = 1'b1;
		end
		a = hi[63:32];
		b = hi[31:0];
		c = lo[63:32];
		d = lo[31:0];
		for (int i = 0; i < n; i++) begin
			rk = round_key[(f == DECRYPT) ? (n - 1 - i) : i];
			kh = rk[63:32];
			kl = rk[31:0];
			if (f == ENCRYPT) begin
				if (i % 2 == 0) begin
					t = b ^ c;
					b ^= kh;
					c ^= kl;
					a = rol32(a, 6) + rol32(t, 9);
					d = rol32(d, 15) + rol32(t, 14);
				end else begin
					t = a ^ d;
					b = rol32(b, 6) + rol32(t, 9);
					c = rol32(c, 15) + rol32(t, 14);
					a ^= kh;
					d ^= kl;
				end
			end else begin
				if (i % 2 == 0) begin
					b ^= kh;
					c ^= kl;
					t = b ^ c;
					a = rol32(a - rol32(t, 9), 26);
					d = rol32(d - rol32(t, 14), 17);
				end else begin
					a ^= kh;
					d ^= kl;
					t = a ^ d;
					b = rol32(b - rol32(t, 9), 26);
					c = rol32(c - rol32(t, 14), 17);
				end
			end
		end
		awaited_hi.push_back({b, a});
		awaited_lo.push_back({d, c});
	endfunction

	function void check_block(logic [63:0] hi, logic [63:0] lo);
		logic [63:0] want_hi, want_lo;
		if (awaited_hi.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: result with no word outstanding: %h %h", $time, hi, lo);
			return;
		end
		want_hi = awaited_hi.pop_front();
		want_lo = awaited_lo.pop_front();
		if (hi !== want_hi) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: result_hi expected %h, got %h", $time, want_hi, hi);
		end
		if (lo !== want_lo) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: result_lo expected %h, got %h", $time, want_lo, lo);
		end
	endfunction
endclass

module tb_ballet128_block_cipher;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int END_WAIT       = 2 * ROUNDS_LONG_KEY + 16;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  func;
	logic [BLOCK_W-1:0]    block_hi;
	logic [BLOCK_W-1:0]    block_lo;
	logic                  out_valid;
	logic                  out_stall;
	logic [BLOCK_W-1:0]    result_hi;
	logic [BLOCK_W-1:0]    result_lo;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    idle_cycles = 0;
	block_tracker          tracker = new();

	ballet128_block_cipher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.block_hi  (block_hi),
		.block_lo  (block_lo),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_hi (result_hi),
		.result_lo (result_lo),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, 63);
			3:       return ~(64'd1 << $urandom_range(0, 63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_block(cipher_func_e f, logic [63:0] hi, logic [63:0] lo);
		@(negedge clk);
		in_valid <= 1'b1;
		func     <= f;
		block_hi <= hi;
		block_lo <= lo;
		do @(posedge clk); while (in_stall);
		tracker.note_block(f, hi, lo);
	endtask

	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			func     <= 1'($urandom_range(0, 1));
			block_hi <= {$urandom, $urandom};
			block_lo <= {$urandom, $urandom};
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// hold off until every word has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.awaited_hi.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_reg(idx, data);
	endtask

	task automatic write_key(logic [63:0] w, logic long_sel);
		for (int r = REG_KEY_W0; r <= REG_KEY_W3; r++)
			write_reg(CFG_IDX_W'(r), w);
		write_reg(REG_KEY_LENGTH, {{63{~long_sel}}, long_sel});
	endtask

	task automatic send_edges();
		logic [63:0] edge_hi [3];
		logic [63:0] edge_lo [3];
		edge_hi = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000};
		edge_lo = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001};
		for (int v = 0; v < 3; v++) begin
			send_block(ENCRYPT, edge_hi[v], edge_lo[v]);
			send_block(DECRYPT, edge_hi[v], edge_lo[v]);
		end
	endtask

	task automatic rekey(bit all_regs);
		drain();
		for (int r = REG_KEY_W0; r <= REG_KEY_LENGTH; r++)
			if (all_regs || $urandom_range(0, 1))
				write_reg(CFG_IDX_W'(r), rand_word());
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_KEY_LENGTH + CFG_IDX_W'($urandom_range(1, 3)), rand_word());
	endtask

	task automatic random_traffic(int count);
		int sent;
		int burst;
		int gap_mode;
		sent     = 0;
		gap_mode = $urandom_range(0, 2);
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int j = 0; j < burst && sent < count; j++) begin
				send_block(cipher_func_e'($urandom_range(0, 1)), rand_word(), rand_word());
				sent++;
			end
			case (gap_mode)
				0: ;
				1: pause_sender($urandom_range(1, 6));
				default: pause_sender($urandom_range(0, 60));
			endcase
			if ($urandom_range(0, 19) == 0)
				drain();
		end
	endtask

	initial begin
		int mode;
		int span;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 400);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_block(result_hi, result_lo);
	end

	always @(posedge clk) begin
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = 1'b0;
		block_hi  = '0;
		block_lo  = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_edges();
		drain();
		write_key('1, 1'b1);
		send_edges();
		drain();
		write_key('0, 1'b1);
		write_reg(REG_KEY_LENGTH + CFG_IDX_W'(1), '1);
		send_block(ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom});
		send_block(DECRYPT, {$urandom, $urandom}, {$urandom, $urandom});
		drain();
		write_key('1, 1'b0);
		send_edges();

		for (int p = 0; p < 12; p++) begin
			rekey(p == 0);
			random_traffic(158);
		end

		drain();
		repeat (END_WAIT) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.awaited_hi.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
